### rtl/positional_list_store_defines.svh
// assertion helpers, clocked on i_clk and held off while i_rst_n is low
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// same-cycle implication
`define PLS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("positional list store: same-cycle check failed");

// next-cycle implication
`define PLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("positional list store: next-cycle check failed");

`endif

### rtl/pls_pkg.sv
`default_nettype none

package pls_pkg;

    typedef logic signed [31:0] t_word;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CC_HOLD,
        CC_INSERT,
        CC_DELETE,
        CC_ROTATE
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd  cmd;
        logic [4:0] idx;
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

endpackage

`default_nettype wire

### rtl/pls_in_if.sv
`default_nettype none

interface pls_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [4:0]         position;
    logic signed [31:0] value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

`default_nettype wire

### rtl/pls_out_if.sv
`default_nettype none

interface pls_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [4:0]         length;
    logic signed [31:0] element;
    logic               element_valid;
    logic               last;

    modport source (output valid, output status, output length, output element,
                    output element_valid, output last, input ready);
    modport sink   (input valid, input status, input length, input element,
                    input element_valid, input last, output ready);
endinterface

`default_nettype wire

### rtl/positional_list_store.sv
// insert, delete and bad codes: one result beat, registered on the accepting edge;
//   a new item can be taken every cycle while the result register drains
// dump: one beat per held element, one a cycle unless the output stalls, read from the
//   head cell while the cell chain rotates; no item is taken until the last beat is loaded
// reset clears the element count, the dump state and the result valid; cell contents
//   stay undefined and are never shown before being written
`default_nettype none

`include "positional_list_store_defines.svh"

module positional_list_store #(
    parameter int CAPACITY = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pls_in_if.sink     i_in,
    pls_out_if.source  o_out
);
    import pls_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_dump_cnt, n_dump_cnt;
    logic            r_out_valid, n_out_valid;
    t_status         r_status, n_status;
    logic [4:0]      r_length, n_length;
    t_word           r_element, n_element;
    logic            r_elem_valid, n_elem_valid;
    logic            r_last, n_last;

    t_cell_ctl       cell_ctl;
    t_word           cell_val [CAPACITY];
    logic [CW-1:0]   cnt_m1;
    logic [CMPW-1:0] pos_w, cnt_w;
    logic            slot_free, in_fire, dump_step, dump_last;
    logic            ins_range, ins_full, del_range;
    t_op             op;

    assign slot_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && slot_free;
    assign in_fire    = i_in.valid && i_in.ready;
    assign op         = t_op'(i_in.operation);

    assign cnt_m1    = r_count - 1'b1;
    assign pos_w     = CMPW'(i_in.position);
    assign cnt_w     = CMPW'(r_count);
    assign ins_range = pos_w > (cnt_w + 1'b1);
    assign ins_full  = r_count == CW'(CAPACITY);
    assign del_range = (r_count == '0) || (pos_w > cnt_w);

    assign dump_step = (r_state == S_DUMP) && slot_free;
    assign dump_last = r_dump_cnt == cnt_m1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && op == OP_DUMP && r_count > CW'(1)) begin
                    n_state = S_DUMP;
                end
            end
            S_DUMP: begin
                if (dump_step && dump_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result control
    always_comb begin
        cell_ctl.cmd = CC_HOLD;
        cell_ctl.idx = (i_in.position == '0) ? 5'd0 : i_in.position - 5'd1;
        n_count      = r_count;
        n_dump_cnt   = r_dump_cnt;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_status     = r_status;
        n_length     = r_length;
        n_element    = r_element;
        n_elem_valid = r_elem_valid;
        n_last       = r_last;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_out_valid  = 1'b1;
                    n_status     = ST_OK;
                    n_element    = '0;
                    n_elem_valid = 1'b0;
                    n_last       = 1'b1;
                    case (op)
                        OP_INSERT: begin
                            if (ins_range) begin
                                n_status = ST_RANGE;
                            end else if (ins_full) begin
                                n_status = ST_FULL;
                            end else begin
                                cell_ctl.cmd = CC_INSERT;
                                n_count      = r_count + 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            if (del_range) begin
                                n_status = ST_RANGE;
                            end else begin
                                cell_ctl.cmd = CC_DELETE;
                                n_count      = r_count - 1'b1;
                            end
                        end
                        OP_DUMP: begin
                            if (r_count != '0) begin
                                cell_ctl.cmd = CC_ROTATE;
                                n_element    = cell_val[0];
                                n_elem_valid = 1'b1;
                                n_last       = (r_count == CW'(1));
                                n_dump_cnt   = CW'(1);
                            end
                        end
                        default: n_status = ST_RANGE;
                    endcase
                    n_length = 5'(n_count);
                end
            end
            S_DUMP: begin
                if (dump_step) begin
                    cell_ctl.cmd = CC_ROTATE;
                    n_out_valid  = 1'b1;
                    n_status     = ST_OK;
                    n_length     = 5'(r_count);
                    n_element    = cell_val[0];
                    n_elem_valid = 1'b1;
                    n_last       = dump_last;
                    n_dump_cnt   = r_dump_cnt + 1'b1;
                end
            end
            default: cell_ctl.cmd = CC_HOLD;
        endcase
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_word left_val, right_val;
        if (k == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_inner_l
            assign left_val = cell_val[k-1];
        end
        if (k == CAPACITY - 1) begin : g_end
            assign right_val = '0;
        end else begin : g_inner_r
            assign right_val = cell_val[k+1];
        end

        pls_cell #(
            .IDX (k),
            .IW  (IW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_tail  (cnt_m1[IW-1:0]),
            .i_left  (left_val),
            .i_right (right_val),
            .i_head  (cell_val[0]),
            .i_ins   (i_in.value),
            .o_value (cell_val[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dump_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dump_cnt  <= n_dump_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_length     <= n_length;
        r_element    <= n_element;
        r_elem_valid <= n_elem_valid;
        r_last       <= n_last;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.length        = r_length;
    assign o_out.element       = r_element;
    assign o_out.element_valid = r_elem_valid;
    assign o_out.last          = r_last;

    `PLS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY))
    `PLS_ASSERT_NEXT(a_insert_grows,
        in_fire && op == OP_INSERT && !ins_range && !ins_full,
        r_count == $past(r_count) + 1'b1)
    `PLS_ASSERT_NOW(a_dump_blocks_input, r_state == S_DUMP, !i_in.ready)
    `PLS_ASSERT_NOW(a_not_last_in_dump, r_out_valid && !r_last, r_state == S_DUMP)

endmodule

`default_nettype wire

### rtl/pls_cell.sv
`default_nettype none

module pls_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  wire logic              i_clk,
    input  wire pls_pkg::t_cell_ctl i_ctl,
    input  wire logic [IW-1:0]     i_tail,
    input  wire pls_pkg::t_word    i_left,
    input  wire pls_pkg::t_word    i_right,
    input  wire pls_pkg::t_word    i_head,
    input  wire pls_pkg::t_word    i_ins,
    output pls_pkg::t_word         o_value
);
    import pls_pkg::*;

    t_word r_value;
    t_word n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.cmd)
            CC_INSERT: begin
                if (IDX > int'(i_ctl.idx)) begin
                    n_value = i_left;
                end else if (IDX == int'(i_ctl.idx)) begin
                    n_value = i_ins;
                end
            end
            CC_DELETE: begin
                if (IDX >= int'(i_ctl.idx)) begin
                    n_value = i_right;
                end
            end
            // the occupied run turns one place towards the head, head wraps to the tail
            CC_ROTATE: begin
                if (IDX == int'(i_tail)) begin
                    n_value = i_head;
                end else if (IDX < int'(i_tail)) begin
                    n_value = i_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire
